// ===== rtl/mbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types and constants for the mipmap box downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int NUM_CHAN    = 4;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = NUM_CHAN * CHAN_W;
  localparam int PAIR_W      = CHAN_W + 1;
  localparam int ENTRY_W     = NUM_CHAN * PAIR_W;
  localparam int LOG2_W      = 4;
  localparam int CFG_INDEX_W = 2;

  localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WIDTH_LOG2  = 2'd0,
    REG_HEIGHT_LOG2 = 2'd1
  } cfg_reg_t;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;
  typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] pair_sum_t;

  typedef struct packed {
    logic odd_col;
    logic even_row;
    logic one_col;
    logic one_row;
    logic done;
  } pos_ctrl_t;

endpackage

// ===== rtl/mbd_ram.sv =====
// ----------------------------------------------------------------------------
// mbd_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mbd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mipmap_box_downsampler.sv =====
// ----------------------------------------------------------------------------
// mipmap_box_downsampler
// 2x2 box filter for RGBA8 raster images, emits the next mip level.
// ----------------------------------------------------------------------------
// Output path: the pixel that completes a 2x2 block is registered in stage s1,
//   and its result is then registered onto m_axis.
// Throughput: one pixel per cycle unless m_axis back-pressure holds a result;
//   the line buffer RAM does one read and one write per cycle.
// Reset: counters and held pixel clear, both size registers return to 8;
//   line buffer contents are left as they are, each entry is written first.
module mipmap_box_downsampler #(
  parameter int MAX_WIDTH  = mbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mbd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // red_in, green_in, blue_in, alpha_in
  input  logic [mbd_pkg::PIX_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [mbd_pkg::PIX_W-1:0]       m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbd_pkg::LOG2_W-1:0]      cfg_data
);

  localparam int CW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW         = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [mbd_pkg::LOG2_W-1:0] WLG_MAX =
    mbd_pkg::LOG2_W'($clog2(MAX_WIDTH + 1) - 1);
  localparam logic [mbd_pkg::LOG2_W-1:0] HLG_MAX =
    mbd_pkg::LOG2_W'($clog2(MAX_HEIGHT + 1) - 1);

  logic [mbd_pkg::LOG2_W-1:0] width_log2;
  logic [mbd_pkg::LOG2_W-1:0] height_log2;
  logic [mbd_pkg::LOG2_W-1:0] wlg;
  logic [mbd_pkg::LOG2_W-1:0] hlg;
  logic [CW:0]                wfull;
  logic [RW:0]                hfull;
  logic [CW-1:0]              wmask;
  logic [RW-1:0]              hmask;

  logic [CW-1:0]              column_count;
  logic [RW-1:0]              row_count;
  logic                       col_last;
  logic                       row_last;
  logic                       cfg_fire;
  logic                       s_fire;
  mbd_pkg::pos_ctrl_t         pos_next;
  logic [AW-1:0]              idx_next;

  logic                       s1_valid;
  mbd_pkg::pixel_t            s1_px;
  mbd_pkg::pos_ctrl_t         s1_ctrl;
  logic [AW-1:0]              s1_idx;
  logic                       s1_fire;
  logic                       emit;

  mbd_pkg::pixel_t            left_pixel_hold;
  mbd_pkg::pair_sum_t         hs;
  mbd_pkg::pair_sum_t         line_entry;
  mbd_pkg::pixel_t            result;
  logic [mbd_pkg::ENTRY_W-1:0] ram_rdata;
  logic                       ram_we;
  logic                       byp_hit;
  logic [mbd_pkg::ENTRY_W-1:0] byp_data;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2  <= mbd_pkg::LOG2_RESET;
      height_log2 <= mbd_pkg::LOG2_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        mbd_pkg::REG_WIDTH_LOG2:  width_log2  <= cfg_data;
        mbd_pkg::REG_HEIGHT_LOG2: height_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wlg   = (width_log2 > WLG_MAX) ? WLG_MAX : width_log2;
  assign hlg   = (height_log2 > HLG_MAX) ? HLG_MAX : height_log2;
  assign wfull = (CW + 1)'(1) << wlg;
  assign hfull = (RW + 1)'(1) << hlg;
  assign wmask = CW'(wfull - 1'b1);
  assign hmask = RW'(hfull - 1'b1);

  assign col_last = (column_count == wmask);
  assign row_last = (row_count == hmask);

  assign s1_fire       = s1_valid & (~emit | ~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~s1_valid | s1_fire;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    pos_next.one_col  = (wlg == '0);
    pos_next.one_row  = (hlg == '0);
    pos_next.odd_col  = pos_next.one_col | column_count[0];
    pos_next.even_row = ~row_count[0];
    pos_next.done     = col_last & row_last;
    idx_next          = AW'(column_count >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (s_fire) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_px   <= mbd_pkg::pixel_t'(s_axis_tdata);
      s1_ctrl <= pos_next;
      s1_idx  <= idx_next;
      byp_hit <= ram_we && (s1_idx == idx_next);
      byp_data <= mbd_pkg::ENTRY_W'(hs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      left_pixel_hold <= '0;
    end else if (s1_fire && !s1_ctrl.odd_col) begin
      left_pixel_hold <= s1_px;
    end
  end

  assign line_entry = mbd_pkg::pair_sum_t'(byp_hit ? byp_data : ram_rdata);

  always_comb begin
    logic [mbd_pkg::PAIR_W:0] sum;
    for (int c = 0; c < mbd_pkg::NUM_CHAN; c++) begin
      if (s1_ctrl.one_col) begin
        hs[c] = {s1_px[c], 1'b0};
      end else begin
        hs[c] = {1'b0, left_pixel_hold[c]} + {1'b0, s1_px[c]};
      end
      if (s1_ctrl.one_row) begin
        sum = {hs[c], 1'b0};
      end else begin
        sum = {1'b0, line_entry[c]} + {1'b0, hs[c]};
      end
      result[c] = sum[mbd_pkg::PAIR_W:2];
    end
  end

  assign emit   = s1_ctrl.odd_col & (s1_ctrl.one_row | ~s1_ctrl.even_row);
  assign ram_we = s1_fire & s1_ctrl.odd_col & ~s1_ctrl.one_row & s1_ctrl.even_row;

  mbd_ram #(
    .WIDTH (mbd_pkg::ENTRY_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx),
    .wdata (mbd_pkg::ENTRY_W'(hs)),
    .re    (s_fire),
    .raddr (idx_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_fire && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      m_axis_tdata <= mbd_pkg::PIX_W'(result);
      m_axis_tlast <= s1_ctrl.done;
    end
  end

  a_level_wrap: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !cfg_fire && pos_next.done) |=> (column_count == '0 && row_count == '0))
    else $error("counters did not wrap at end of level");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (column_count <= wmask) && (row_count <= hmask))
    else $error("raster position outside image");

  a_write_no_emit: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && emit))
    else $error("line buffer write on a result pixel");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_px) && $stable(s1_idx)))
    else $error("stalled pixel lost");

endmodule
